// ===== rtl/core/sko_pkg.sv =====
package sko_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int KEY_W = 31;
  localparam int OFF_W = 40;
  localparam int POS_W = 9;
  localparam int GROUP = 16;
  localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_TREE1,
    S_TREE2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] offset;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [OFF_W-1:0] found_offset;
    logic [POS_W-1:0] position;
  } result_t;

  // contribution of one cell to the reduction tree
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] off;
  } tap_t;

  typedef struct packed {
    logic cmp_en;
    logic wr_en;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sorted_key_offset_index.sv =====
// channel  | signals             | transfer
// ---------+---------------------+-------------------------------------
// request  | start, busy, item   | edge with start high and busy low
// result   | done, result        | edge ending the single cycle of done
//
// a result follows its request transfer by these steps: compare in every
// cell, two registered stages of the or-tree, then the shift/write across
// the cell row; busy is high throughout, so a new item is taken only once
// the result is out. reset clears the entry count and the sequencer; cell
// contents are left as they are and only cells below the count take part.
// the receiver cannot stall: done lasts one cycle.
module sorted_key_offset_index
  import sko_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  state_t state;
  state_t state_next;
  item_t cmd;
  logic [CNT_W-1:0] count;
  cell_ctrl_t ctrl;
  logic ins_ok;
  logic full;

  logic             lt_v   [DEPTH];
  logic [KEY_W-1:0] key_v  [DEPTH];
  logic [OFF_W-1:0] off_v  [DEPTH];
  tap_t             taps   [DEPTH];
  tap_t             sum;
  logic [IDX_W+POS_W-1:0] pos_wide;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        sko_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .idx      (IDX_W'(i)),
          .count    (count),
          .new_key  (cmd.key),
          .new_off  (cmd.offset),
          .left_key (cmd.key),
          .left_off (cmd.offset),
          .left_lt  (1'b1),
          .lt       (lt_v[i]),
          .key      (key_v[i]),
          .off      (off_v[i]),
          .tap      (taps[i])
        );
      end else begin : g_rest
        sko_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .idx      (IDX_W'(i)),
          .count    (count),
          .new_key  (cmd.key),
          .new_off  (cmd.offset),
          .left_key (key_v[i-1]),
          .left_off (off_v[i-1]),
          .left_lt  (lt_v[i-1]),
          .lt       (lt_v[i]),
          .key      (key_v[i]),
          .off      (off_v[i]),
          .tap      (taps[i])
        );
      end
    end
  endgenerate

  sko_tree u_tree (
    .clk  (clk),
    .taps (taps),
    .sum  (sum)
  );

  assign full = count == CNT_W'(DEPTH);
  assign ins_ok = cmd.kind && !sum.hit && !full;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_CMP;
      S_CMP:   state_next = S_TREE1;
      S_TREE1: state_next = S_TREE2;
      S_TREE2: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    ctrl = '0;
    case (state)
      S_IDLE:  busy = 1'b0;
      S_CMP:   ctrl.cmp_en = 1'b1;
      S_TREE1: ;
      S_TREE2: ;
      S_DONE: begin
        done = 1'b1;
        ctrl.wr_en = ins_ok;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_DONE && ins_ok) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd <= item;
    end
  end

  assign pos_wide = {{POS_W{1'b0}}, sum.idx};

  always_comb begin
    result.found_offset = '0;
    result.position = '0;
    if (!cmd.kind) begin
      if (sum.hit) begin
        result.status = ST_OK;
        result.found_offset = sum.off;
        result.position = pos_wide[POS_W-1:0];
      end else begin
        result.status = ST_MISS;
      end
    end else if (sum.hit) begin
      result.status = ST_DUP;
      result.position = pos_wide[POS_W-1:0];
    end else if (full) begin
      result.status = ST_FULL;
    end else begin
      result.status = ST_OK;
      result.position = pos_wide[POS_W-1:0];
    end
  end

endmodule

// ===== rtl/core/sko_cell.sv =====
module sko_cell
  import sko_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] idx,
  input  logic [CNT_W-1:0] count,
  input  logic [KEY_W-1:0] new_key,
  input  logic [OFF_W-1:0] new_off,
  input  logic [KEY_W-1:0] left_key,
  input  logic [OFF_W-1:0] left_off,
  input  logic             left_lt,
  output logic             lt,
  output logic [KEY_W-1:0] key,
  output logic [OFF_W-1:0] off,
  output tap_t             tap
);

  logic occ;
  logic eq;
  logic boundary;

  assign occ = {1'b0, idx} < count;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt <= occ && (key < new_key);
      eq <= occ && (key == new_key);
    end
  end

  // first cell that is free or whose key is not below the search key
  assign boundary = !lt && left_lt;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && !lt) begin
      if (boundary) begin
        key <= new_key;
        off <= new_off;
      end else begin
        key <= left_key;
        off <= left_off;
      end
    end
  end

  always_comb begin
    tap.hit = eq;
    tap.idx = boundary ? idx : '0;
    tap.off = eq ? off : '0;
  end

endmodule

// ===== rtl/core/sko_tree.sv =====
module sko_tree
  import sko_pkg::*;
(
  input  logic clk,
  input  tap_t taps [DEPTH],
  output tap_t sum
);

  tap_t padded [NGROUP*GROUP];
  tap_t grp [NGROUP];
  tap_t grp_next [NGROUP];
  tap_t sum_next;

  genvar k;
  generate
    for (k = 0; k < NGROUP*GROUP; k++) begin : g_pad
      if (k < DEPTH) begin : g_real
        assign padded[k] = taps[k];
      end else begin : g_zero
        assign padded[k] = '0;
      end
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        grp_next[g] = tap_t'(grp_next[g] | padded[g*GROUP + j]);
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int g = 0; g < NGROUP; g++) begin
      sum_next = tap_t'(sum_next | grp[g]);
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_next;
    sum <= sum_next;
  end

endmodule
